### hw/rtl/rtk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtk_pkg;

  localparam logic [1:0] MODE_HIRA   = 2'd0;
  localparam logic [1:0] MODE_KATA   = 2'd1;
  localparam logic [1:0] MODE_DIRECT = 2'd2;

  localparam logic [7:0] KEY_BACKSPACE = 8'h2A;
  localparam logic [7:0] KEY_RIGHT     = 8'h4F;
  localparam logic [7:0] KEY_LEFT      = 8'h50;
  localparam logic [7:0] KEY_DOWN      = 8'h51;
  localparam logic [7:0] KEY_UP        = 8'h52;
  localparam logic [7:0] CHAR_CR       = 8'h0D;

  localparam logic [15:0] KATA_SHIFT     = 16'h0060;
  localparam logic [15:0] KANA_SMALL_TSU = 16'h3063;
  localparam logic [15:0] KANA_N         = 16'h3093;
  localparam logic [4:0]  ROW_SMALL_Y    = 5'd15;

  localparam logic [15:0] KANA_ROWS [0:17][0:4] = '{
    '{16'h3042, 16'h3044, 16'h3046, 16'h3048, 16'h304A},
    '{16'h304B, 16'h304D, 16'h304F, 16'h3051, 16'h3053},
    '{16'h3055, 16'h3057, 16'h3059, 16'h305B, 16'h305D},
    '{16'h305F, 16'h3061, 16'h3064, 16'h3066, 16'h3068},
    '{16'h306A, 16'h306B, 16'h306C, 16'h306D, 16'h306E},
    '{16'h306F, 16'h3072, 16'h3075, 16'h3078, 16'h307B},
    '{16'h307E, 16'h307F, 16'h3080, 16'h3081, 16'h3082},
    '{16'h3084, 16'h3044, 16'h3086, 16'h3048, 16'h3088},
    '{16'h3089, 16'h308A, 16'h308B, 16'h308C, 16'h308D},
    '{16'h308F, 16'h3044, 16'h3046, 16'h3048, 16'h3092},
    '{16'h304C, 16'h304E, 16'h3050, 16'h3052, 16'h3054},
    '{16'h3056, 16'h3058, 16'h305A, 16'h305C, 16'h305E},
    '{16'h3060, 16'h3062, 16'h3065, 16'h3067, 16'h3069},
    '{16'h3070, 16'h3073, 16'h3076, 16'h3079, 16'h307C},
    '{16'h3071, 16'h3074, 16'h3077, 16'h307A, 16'h307D},
    '{16'h3083, 16'h3043, 16'h3085, 16'h3047, 16'h3087},
    '{16'h3063, 16'h3093, 16'h3093, 16'h3093, 16'h3093},
    '{16'h3041, 16'h3043, 16'h3045, 16'h3047, 16'h3049}
  };

  typedef struct packed {
    logic [15:0] char_out;
    logic        pass_through;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } dec_t;

  function automatic logic [4:0] row_of(input logic [7:0] cons);
    logic [4:0] row;
    case (cons)
      "k": row = 5'd1;
      "s": row = 5'd2;
      "t": row = 5'd3;
      "n": row = 5'd4;
      "h": row = 5'd5;
      "m": row = 5'd6;
      "y": row = 5'd7;
      "r": row = 5'd8;
      "w": row = 5'd9;
      "g": row = 5'd10;
      "z": row = 5'd11;
      "d": row = 5'd12;
      "b": row = 5'd13;
      "p": row = 5'd14;
      "x": row = 5'd17;
      default: row = 5'd0;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rtk_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module rtk_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire logic [7:0]    key_code,
  input  wire logic [7:0]    char_code,
  input  wire logic          ctrl_held,
  input  wire logic [1:0]    space,
  output logic               fire,
  output rtk_pkg::dec_t      dec
);
  import rtk_pkg::*;

  logic [1:0] mode;
  logic [7:0] pending_consonant;
  logic       pending_y;
  logic [1:0] mode_next;
  logic [7:0] pending_consonant_next;
  logic       pending_y_next;

  logic [7:0]  c;
  logic [2:0]  col;
  logic        is_vowel;
  logic        is_cons;
  logic [4:0]  row;
  logic [15:0] shift;
  res_t        pass_res;

  assign c = (char_code >= "A" && char_code <= "Z") ? (char_code | 8'h20) : char_code;
  assign row = row_of(pending_consonant);
  assign shift = (mode == MODE_KATA) ? KATA_SHIFT : 16'h0000;
  assign pass_res = '{char_out: 16'h0000, pass_through: 1'b1, last: 1'b1};

  always_comb begin
    is_vowel = 1'b1;
    col = 3'd0;
    case (c)
      "a": col = 3'd0;
      "i": col = 3'd1;
      "u": col = 3'd2;
      "e": col = 3'd3;
      "o": col = 3'd4;
      default: is_vowel = 1'b0;
    endcase
    is_cons = (row_of(c) != 5'd0);
  end

  always_comb begin
    dec = '0;
    mode_next = mode;
    pending_consonant_next = pending_consonant;
    pending_y_next = pending_y;
    if (key_code == KEY_BACKSPACE) begin
      if (pending_y) begin
        pending_y_next = 1'b0;
      end else if (pending_consonant != 8'h00) begin
        pending_consonant_next = 8'h00;
      end else begin
        dec.count = 2'd1;
        dec.r0 = pass_res;
      end
    end else if (key_code == KEY_RIGHT || key_code == KEY_LEFT || key_code == KEY_DOWN ||
                 key_code == KEY_UP || char_code == CHAR_CR) begin
      dec.count = 2'd1;
      dec.r0 = pass_res;
    end else if (ctrl_held) begin
      if (c == "j") begin
        mode_next = MODE_HIRA;
      end else begin
        dec.count = 2'd1;
        dec.r0 = pass_res;
      end
    end else if (mode == MODE_DIRECT) begin
      dec.count = 2'd1;
      dec.r0 = pass_res;
    end else if (is_vowel) begin
      pending_consonant_next = 8'h00;
      pending_y_next = 1'b0;
      if (pending_y) begin
        dec.count = 2'd2;
        dec.r0 = '{char_out: KANA_ROWS[row][1] + shift, pass_through: 1'b0, last: 1'b0};
        dec.r1 = '{char_out: KANA_ROWS[ROW_SMALL_Y][col] + shift, pass_through: 1'b0,
                   last: 1'b1};
      end else begin
        dec.count = 2'd1;
        dec.r0 = '{char_out: KANA_ROWS[row][col] + shift, pass_through: 1'b0, last: 1'b1};
      end
    end else if (is_cons) begin
      if (pending_consonant == c) begin
        dec.count = 2'd1;
        if (c == "n") begin
          pending_consonant_next = 8'h00;
          pending_y_next = 1'b0;
          dec.r0 = '{char_out: KANA_N + shift, pass_through: 1'b0, last: 1'b1};
        end else begin
          dec.r0 = '{char_out: KANA_SMALL_TSU + shift, pass_through: 1'b0, last: 1'b1};
        end
      end else if (c == "y" && pending_consonant != 8'h00) begin
        pending_y_next = 1'b1;
      end else begin
        if (pending_consonant == "n") begin
          dec.count = 2'd1;
          dec.r0 = '{char_out: KANA_N + shift, pass_through: 1'b0, last: 1'b1};
        end
        pending_consonant_next = c;
      end
    end else if (c == "l") begin
      mode_next = MODE_DIRECT;
    end else if (c == "q") begin
      mode_next = MODE_KATA;
    end else begin
      dec.count = 2'd1;
      dec.r0 = '{char_out: {8'h00, c}, pass_through: 1'b0, last: 1'b1};
    end
  end

  assign fire = item_valid && (dec.count <= space);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_HIRA;
      pending_consonant <= 8'h00;
      pending_y <= 1'b0;
    end else if (fire) begin
      mode <= mode_next;
      pending_consonant <= pending_consonant_next;
      pending_y <= pending_y_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rtk_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module rtk_outbuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rtk_pkg::dec_t dec,
  output logic [1:0]         space,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic [15:0]        char_out,
  output logic               pass_through,
  output logic               last
);
  import rtk_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  res_t       e0;
  res_t       e1;
  res_t       e0_next;
  res_t       e1_next;
  logic       pop;
  logic [1:0] remain;
  logic [1:0] add;

  assign pop = (count != 2'd0) && !result_stall;
  assign remain = count - {1'b0, pop};
  assign space = 2'd2 - remain;
  assign add = push ? dec.count : 2'd0;
  assign count_next = remain + add;

  // head slot first, pushed transactions fill behind what is left
  always_comb begin
    e0_next = e0;
    e1_next = e1;
    case (remain)
      2'd0: begin
        e0_next = dec.r0;
        e1_next = dec.r1;
      end
      2'd1: begin
        e0_next = pop ? e1 : e0;
        e1_next = dec.r0;
      end
      default: begin
        e0_next = e0;
        e1_next = e1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    e0 <= e0_next;
    e1 <= e1_next;
  end

  assign result_valid = (count != 2'd0);
  assign char_out = e0.char_out;
  assign pass_through = e0.pass_through;
  assign last = e0.last;

endmodule

`default_nettype wire

### hw/rtl/romaji_to_kana_transliterator_unit.sv
// Romaji to kana converter for a keyboard front end. Each key transaction
// (key_code, char_code, ctrl_held) is registered on entry, decoded
// combinationally against the mode and the pending consonant/y, and its
// results (none, one, or a kana plus a small y-row kana, the final one marked
// by last) go into a two-entry output queue. One key per cycle is taken when
// results drain freely; a key with two results fills both queue entries, so
// throughput is one result per cycle while result_stall is low, set by the
// single output port. Results with pass_through set carry char_out of zero.
`timescale 1ns / 1ps
`default_nettype none

module romaji_to_kana_transliterator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        key_valid,
  output logic             key_stall,
  input  wire logic [7:0]  key_code,
  input  wire logic [7:0]  char_code,
  input  wire logic        ctrl_held,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [15:0]      char_out,
  output logic             pass_through,
  output logic             last
);
  import rtk_pkg::*;

  logic       full;
  logic [7:0] key_r;
  logic [7:0] char_r;
  logic       ctrl_r;
  logic       fire;
  logic       load;
  logic [1:0] space;
  dec_t       dec;

  assign key_stall = full && !fire;
  assign load = key_valid && !key_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (fire) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= key_code;
      char_r <= char_code;
      ctrl_r <= ctrl_held;
    end
  end

  rtk_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (full),
    .key_code   (key_r),
    .char_code  (char_r),
    .ctrl_held  (ctrl_r),
    .space      (space),
    .fire       (fire),
    .dec        (dec)
  );

  rtk_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .push         (fire),
    .dec          (dec),
    .space        (space),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .char_out     (char_out),
    .pass_through (pass_through),
    .last         (last)
  );

endmodule

`default_nettype wire
